>>> rtl/psi_pkg.sv
package psi_pkg;

  // Field and datapath widths
  localparam int POS_W   = 32;
  localparam int ORI_W   = 16;
  localparam int BQ_W    = 17;
  localparam int T_W     = 17;
  localparam int CONF_W  = 16;
  localparam int MW      = 33;   // multiplier operand
  localparam int PW      = 66;   // multiplier product
  localparam int CW      = 36;   // CORDIC x/y/z
  localparam int QS_W    = 27;   // scaled linear-blend component
  localparam int DOT_W   = 35;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 32;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;

  localparam int NORM_SHIFT   = ORI_W - 8;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = DVD_W;
  localparam int SQRT_STEPS   = RAD_W / 2;

  localparam logic [T_W-1:0]          T_ONE     = 17'd65536;
  localparam logic signed [DOT_W-1:0] DOT_LIMIT = 35'sd268301238;
  localparam logic signed [CW-1:0]    INV_GAIN  = 36'sd652032874;
  localparam logic signed [PW-1:0]    RND16     = 66'sd32768;
  localparam logic signed [PW-1:0]    RND30     = 66'sd536870912;
  localparam logic [RAD_W-1:0]        ONE_Q60   = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic                     action;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [ORI_W-1:0]  quat_w;
    logic signed [ORI_W-1:0]  quat_x;
    logic signed [ORI_W-1:0]  quat_y;
    logic signed [ORI_W-1:0]  quat_z;
    logic [CONF_W-1:0]        pos_conf;
    logic [CONF_W-1:0]        orient_conf;
    logic                     pose_valid;
    logic [T_W-1:0]           blend_t;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
    logic signed [ORI_W-1:0]  out_qw;
    logic signed [ORI_W-1:0]  out_qx;
    logic signed [ORI_W-1:0]  out_qy;
    logic signed [ORI_W-1:0]  out_qz;
    logic [CONF_W-1:0]        out_pos_conf;
    logic [CONF_W-1:0]        out_orient_conf;
    logic                     out_valid;
  } out_item_t;

  typedef enum logic {
    CM_VECTOR,
    CM_ROTATE
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_POS_M, ST_POS_A, ST_DOT_M, ST_DOT_A, ST_SIGN,
    ST_LIN_M, ST_LIN_A, ST_LSQ_M, ST_LSQ_A, ST_LSQRT, ST_LSQRT_W,
    ST_LDIV, ST_LDIV_W,
    ST_SQD_M, ST_SQD_A, ST_SQ_W, ST_VEC, ST_VEC_W, ST_TH_M, ST_TH_A,
    ST_ROT_W, ST_S1, ST_S1_W, ST_DS_M, ST_DS_A,
    ST_SL_M, ST_SL_A, ST_SL_M2, ST_SL_A2, ST_FIN
  } state_e;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'({1'b0, {(POS_W-1){1'b1}}});
    lo = -hi - 66'sd1;
    if (v > hi) sat_pos = hi[POS_W-1:0];
    else if (v < lo) sat_pos = lo[POS_W-1:0];
    else sat_pos = v[POS_W-1:0];
  endfunction

  function automatic logic signed [ORI_W-1:0] sat_ori(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'({1'b0, {(ORI_W-1){1'b1}}});
    lo = -hi - 66'sd1;
    if (v > hi) sat_ori = hi[ORI_W-1:0];
    else if (v < lo) sat_ori = lo[ORI_W-1:0];
    else sat_ori = v[ORI_W-1:0];
  endfunction

  // atan(2^-i) in Q2.30
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic [CW-1:0] one;
    one = CW'(1);
    case (i)
      5'd0:    atan_q30 = 36'sd843314857;
      5'd1:    atan_q30 = 36'sd497837829;
      5'd2:    atan_q30 = 36'sd263043837;
      5'd3:    atan_q30 = 36'sd133525159;
      5'd4:    atan_q30 = 36'sd67021687;
      5'd5:    atan_q30 = 36'sd33543516;
      5'd6:    atan_q30 = 36'sd16775851;
      5'd7:    atan_q30 = 36'sd8388437;
      5'd8:    atan_q30 = 36'sd4194283;
      5'd9:    atan_q30 = 36'sd2097149;
      default: atan_q30 = $signed(one << (5'd30 - i));
    endcase
  endfunction

endpackage

>>> rtl/psi_mul.sv
module psi_mul (
  input  logic                          clk_i,
  input  logic signed [psi_pkg::MW-1:0] a_i,
  input  logic signed [psi_pkg::MW-1:0] b_i,
  output logic signed [psi_pkg::PW-1:0] p_o
);
  import psi_pkg::*;

  logic signed [PW-1:0] p_q;

  // Registered signed product, one per cycle
  always_ff @(posedge clk_i) begin
    p_q <= PW'(a_i) * PW'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> rtl/psi_div.sv
module psi_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [psi_pkg::DVD_W-1:0]        dividend_i,
  input  logic [psi_pkg::DVS_W-1:0]        divisor_i,
  output logic [psi_pkg::DVD_W-1:0]        quot_o,
  output logic                             done_o
);
  import psi_pkg::*;

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   sh;
  logic             fit;

  // One quotient bit per cycle, restoring
  assign sh  = {rem_q, dvd_q[DVD_W-1]};
  assign fit = (sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? DVS_W'(sh - {1'b0, dvs_q}) : sh[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fit};
    end
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

>>> rtl/psi_sqrt.sv
module psi_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [psi_pkg::RAD_W-1:0]  rad_i,
  output logic [psi_pkg::ROOT_W-1:0] root_o,
  output logic                       done_o
);
  import psi_pkg::*;

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [4:0]        cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [ROOT_W+2:0] sh;
  logic [ROOT_W+2:0] trial;
  logic              fit;

  // Floor square root, two radicand bits per cycle
  assign sh    = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fit   = (sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fit ? (ROOT_W + 1)'(sh - trial) : sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], fit};
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

>>> rtl/psi_cordic.sv
module psi_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psi_pkg::cordic_cmd_t          cmd_i,
  input  logic signed [psi_pkg::CW-1:0] x0_i,
  input  logic signed [psi_pkg::CW-1:0] y0_i,
  input  logic signed [psi_pkg::CW-1:0] z0_i,
  output logic signed [psi_pkg::CW-1:0] x_o,
  output logic signed [psi_pkg::CW-1:0] y_o,
  output logic signed [psi_pkg::CW-1:0] z_o,
  output logic                          done_o
);
  import psi_pkg::*;

  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [CW-1:0] xs, ys, ang;
  cordic_mode_e         mode_q;
  logic [4:0]           cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic                 dir_pos;

  // Shared micro-rotation: one step per cycle
  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = atan_q30(cnt_q);

  // Rotation drives z to zero, vectoring drives y to zero
  always_comb begin
    case (mode_q)
      CM_ROTATE: dir_pos = (z_q >= 0);
      CM_VECTOR: dir_pos = (y_q < 0);
      default:   dir_pos = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= x0_i;
      y_q    <= y0_i;
      z_q    <= z0_i;
      mode_q <= cmd_i.mode;
    end else if (busy_q) begin
      if (dir_pos) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

>>> rtl/pose_slerp_interpolator.sv
// Channel | Dir | Handshake              | Payload
// in      | in  | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
// out     | out | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// A store item (action 0) updates pose A while the block stays idle. An
// interpolate item takes the slerp path (shared 64-step divider, 32-step square
// root, 30-step CORDIC) or the near-parallel path (square root and divider, no CORDIC).
// in_stall_o is high while an interpolate item is in work.
// The result sits in an output register; a new item is taken while it waits.
// Reset is asynchronous, active low, and clears the stored pose A to zero.
module pose_slerp_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psi_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psi_pkg::out_item_t  out_data_o
);
  import psi_pkg::*;

  state_e state_q, state_d;
  logic [1:0] idx_q;

  // Stored pose A
  logic signed [POS_W-1:0] a_pos_q [3];
  logic signed [ORI_W-1:0] a_q_q   [4];
  logic [CONF_W-1:0]       a_pc_q, a_oc_q;
  logic                    a_vld_q;

  // Working registers
  logic signed [POS_W-1:0] b_pos_q [3];
  logic signed [BQ_W-1:0]  bq_q    [4];
  logic signed [QS_W-1:0]  qs_q    [4];
  logic signed [POS_W-1:0] opos_q  [3];
  logic signed [ORI_W-1:0] oq_q    [4];
  logic [T_W-1:0]          t_q;
  logic [CONF_W-1:0]       pc_q, oc_q;
  logic                    vld_q;
  logic signed [DOT_W-1:0] dot_q;
  logic [RAD_W-1:0]        ss_q;
  logic [ROOT_W-1:0]       sn0_q;
  logic signed [CW-1:0]    z_q, cos_q, sin_q;
  logic signed [MW-1:0]    s1_q, s0_q;
  logic signed [PW-1:0]    acc_q;
  out_item_t               out_q;
  logic                    out_valid_q;

  // Unit interfaces
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic                 sqrt_start, sqrt_done;
  logic [RAD_W-1:0]     sqrt_rad;
  logic [ROOT_W-1:0]    sqrt_root;
  logic                 div_start, div_done;
  logic [DVD_W-1:0]     div_dvd, div_q;
  logic [DVS_W-1:0]     div_dvs;
  cordic_cmd_t          cor_cmd;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
  logic                 cor_done_w;

  // Datapath helpers
  logic                    in_xfer, out_free;
  logic signed [DOT_W-1:0] abs_dot;
  logic signed [MW-1:0]    d_s, t_op;
  logic signed [PW-1:0]    rnd16, pos_sum, q_lin, ds_rnd, sl_sum;
  logic signed [CW-1:0]    th_w, sin_mag;
  logic signed [QS_W-1:0]  qs_cur;
  logic [QS_W-1:0]         qs_mag;
  logic [DVD_W-1:0]        lim;
  logic [DVD_W-1:0]        qclip;
  logic signed [ORI_W:0]   q17;
  logic [MW-1:0]           s1m;
  logic [CONF_W-1:0]       pc_max, oc_max;
  logic [T_W-1:0]          t_clamp;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign abs_dot = dot_q[DOT_W-1] ? -dot_q : dot_q;
  assign d_s     = MW'($signed({1'b0, dot_q[27:0], 2'b00}));
  assign t_op    = MW'($signed({1'b0, t_q}));
  assign rnd16   = (mul_p + RND16) >>> 16;
  assign pos_sum = rnd16 + PW'(a_pos_q[idx_q]);
  assign q_lin   = (PW'(a_q_q[idx_q]) <<< 16) + mul_p;
  assign th_w    = CW'(rnd16);
  assign ds_rnd  = (mul_p + RND30) >>> 30;
  assign sl_sum  = (acc_q + mul_p + RND30) >>> 30;
  assign sin_mag = (sin_q < 0) ? -sin_q : sin_q;
  assign qs_cur  = qs_q[idx_q];
  assign qs_mag  = (qs_cur < 0) ? QS_W'(-qs_cur) : QS_W'(qs_cur);

  // Rounded normalize quotient, saturated toward the sign of the component
  assign lim   = (qs_cur < 0) ? DVD_W'(32768) : DVD_W'(32767);
  assign qclip = (div_q > lim) ? lim : div_q;
  assign q17   = (qs_cur < 0) ? -$signed({1'b0, qclip[ORI_W-1:0]})
                              : $signed({1'b0, qclip[ORI_W-1:0]});
  // Slerp weight magnitude clamped at 2.0
  assign s1m   = (div_q > DVD_W'(64'h8000_0000)) ? MW'(33'h0_8000_0000) : div_q[MW-1:0];

  assign pc_max  = (a_pc_q > in_data_i.pos_conf) ? a_pc_q : in_data_i.pos_conf;
  assign oc_max  = (a_oc_q > in_data_i.orient_conf) ? a_oc_q : in_data_i.orient_conf;
  assign t_clamp = (in_data_i.blend_t > T_ONE) ? T_ONE : in_data_i.blend_t;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_xfer && in_data_i.action) state_d = ST_POS_M;
      ST_POS_M:   state_d = ST_POS_A;
      ST_POS_A:   state_d = (idx_q == 2'd2) ? ST_DOT_M : ST_POS_M;
      ST_DOT_M:   state_d = ST_DOT_A;
      ST_DOT_A:   state_d = (idx_q == 2'd3) ? ST_SIGN : ST_DOT_M;
      ST_SIGN:    state_d = (abs_dot > DOT_LIMIT) ? ST_LIN_M : ST_SQD_M;
      ST_LIN_M:   state_d = ST_LIN_A;
      ST_LIN_A:   state_d = (idx_q == 2'd3) ? ST_LSQ_M : ST_LIN_M;
      ST_LSQ_M:   state_d = ST_LSQ_A;
      ST_LSQ_A:   state_d = (idx_q == 2'd3) ? ST_LSQRT : ST_LSQ_M;
      ST_LSQRT:   state_d = ST_LSQRT_W;
      ST_LSQRT_W: if (sqrt_done) state_d = ST_LDIV;
      ST_LDIV:    state_d = (sn0_q == '0) ? ST_FIN : ST_LDIV_W;
      ST_LDIV_W:  if (div_done) state_d = (idx_q == 2'd3) ? ST_FIN : ST_LDIV;
      ST_SQD_M:   state_d = ST_SQD_A;
      ST_SQD_A:   state_d = ST_SQ_W;
      ST_SQ_W:    if (sqrt_done) state_d = ST_VEC;
      ST_VEC:     state_d = ST_VEC_W;
      ST_VEC_W:   if (cor_done_w) state_d = ST_TH_M;
      ST_TH_M:    state_d = ST_TH_A;
      ST_TH_A:    state_d = ST_ROT_W;
      ST_ROT_W:   if (cor_done_w) state_d = ST_S1;
      ST_S1:      state_d = ST_S1_W;
      ST_S1_W:    if (div_done) state_d = ST_DS_M;
      ST_DS_M:    state_d = ST_DS_A;
      ST_DS_A:    state_d = ST_SL_M;
      ST_SL_M:    state_d = ST_SL_A;
      ST_SL_A:    state_d = ST_SL_M2;
      ST_SL_M2:   state_d = ST_SL_A2;
      ST_SL_A2:   state_d = (idx_q == 2'd3) ? ST_FIN : ST_SL_M;
      ST_FIN:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Unit operands and starts
  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    mul_a          = '0;
    mul_b          = '0;
    sqrt_start     = 1'b0;
    sqrt_rad       = ss_q;
    div_start      = 1'b0;
    div_dvd        = (DVD_W'(qs_mag) << 14) + DVD_W'(sn0_q[ROOT_W-1:1]);
    div_dvs        = sn0_q;
    cor_cmd.start  = 1'b0;
    cor_cmd.mode   = CM_VECTOR;
    cor_x0         = CW'(d_s);
    cor_y0         = CW'($signed({1'b0, sn0_q}));
    cor_z0         = '0;
    case (state_q)
      ST_POS_M: begin
        mul_a = MW'(b_pos_q[idx_q]) - MW'(a_pos_q[idx_q]);
        mul_b = t_op;
      end
      ST_DOT_M: begin
        mul_a = MW'(a_q_q[idx_q]);
        mul_b = MW'(bq_q[idx_q]);
      end
      ST_LIN_M: begin
        mul_a = MW'(bq_q[idx_q]) - MW'(a_q_q[idx_q]);
        mul_b = t_op;
      end
      ST_LSQ_M: begin
        mul_a = MW'(qs_cur);
        mul_b = MW'(qs_cur);
      end
      ST_LSQRT: sqrt_start = 1'b1;
      ST_LDIV:  div_start = (sn0_q != '0);
      ST_SQD_M: begin
        mul_a = d_s;
        mul_b = d_s;
      end
      ST_SQD_A: begin
        sqrt_start = 1'b1;
        sqrt_rad   = ONE_Q60 - mul_p[RAD_W-1:0];
      end
      ST_VEC:   cor_cmd.start = 1'b1;
      ST_TH_M: begin
        mul_a = MW'(z_q);
        mul_b = t_op;
      end
      ST_TH_A: begin
        cor_cmd.start = 1'b1;
        cor_cmd.mode  = CM_ROTATE;
        cor_x0        = INV_GAIN;
        cor_y0        = '0;
        cor_z0        = th_w;
      end
      ST_S1: begin
        div_start = 1'b1;
        div_dvd   = {sin_mag[DVD_W-31:0], 30'b0};
        div_dvs   = (sn0_q == '0) ? DVS_W'(1) : sn0_q;
      end
      ST_DS_M: begin
        mul_a = d_s;
        mul_b = s1_q;
      end
      ST_SL_M: begin
        mul_a = MW'(a_q_q[idx_q]);
        mul_b = s0_q;
      end
      ST_SL_M2: begin
        mul_a = MW'(bq_q[idx_q]);
        mul_b = s1_q;
      end
      default: ;
    endcase
  end

  // Control state and stored pose A
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      a_pc_q      <= '0;
      a_oc_q      <= '0;
      a_vld_q     <= 1'b0;
      for (int k = 0; k < 3; k++) a_pos_q[k] <= '0;
      for (int k = 0; k < 4; k++) a_q_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (in_xfer && !in_data_i.action) begin
        a_pos_q[0] <= in_data_i.pos_x;
        a_pos_q[1] <= in_data_i.pos_y;
        a_pos_q[2] <= in_data_i.pos_z;
        a_q_q[0]   <= in_data_i.quat_w;
        a_q_q[1]   <= in_data_i.quat_x;
        a_q_q[2]   <= in_data_i.quat_y;
        a_q_q[3]   <= in_data_i.quat_z;
        a_pc_q     <= in_data_i.pos_conf;
        a_oc_q     <= in_data_i.orient_conf;
        a_vld_q    <= in_data_i.pose_valid;
      end

      // Component index for the three-step position loop and the four-step loops
      case (state_q)
        ST_IDLE:   idx_q <= '0;
        ST_POS_A:  idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        ST_DOT_A, ST_LIN_A, ST_LSQ_A, ST_SL_A2: idx_q <= idx_q + 2'd1;
        ST_LDIV_W: if (div_done) idx_q <= idx_q + 2'd1;
        ST_SIGN:   idx_q <= '0;
        default: ;
      endcase
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_data_i.action) begin
          b_pos_q[0] <= in_data_i.pos_x;
          b_pos_q[1] <= in_data_i.pos_y;
          b_pos_q[2] <= in_data_i.pos_z;
          bq_q[0]    <= BQ_W'(in_data_i.quat_w);
          bq_q[1]    <= BQ_W'(in_data_i.quat_x);
          bq_q[2]    <= BQ_W'(in_data_i.quat_y);
          bq_q[3]    <= BQ_W'(in_data_i.quat_z);
          t_q        <= t_clamp;
          pc_q       <= pc_max;
          oc_q       <= oc_max;
          vld_q      <= a_vld_q & in_data_i.pose_valid;
          dot_q      <= '0;
        end
      end
      ST_POS_A: opos_q[idx_q] <= sat_pos(pos_sum);
      ST_DOT_A: dot_q <= dot_q + DOT_W'(mul_p);
      ST_SIGN: begin
        ss_q <= '0;
        if (dot_q < 0) begin
          dot_q <= -dot_q;
          for (int k = 0; k < 4; k++) bq_q[k] <= -bq_q[k];
        end
      end
      ST_LIN_A:   qs_q[idx_q] <= QS_W'(q_lin >>> NORM_SHIFT);
      ST_LSQ_A:   ss_q <= ss_q + mul_p[RAD_W-1:0];
      ST_LSQRT_W: if (sqrt_done) sn0_q <= sqrt_root;
      ST_LDIV: begin
        if (sn0_q == '0) begin
          for (int k = 0; k < 4; k++) oq_q[k] <= '0;
        end
      end
      ST_LDIV_W:  if (div_done) oq_q[idx_q] <= q17[ORI_W-1:0];
      ST_SQ_W:    if (sqrt_done) sn0_q <= sqrt_root;
      ST_VEC_W:   if (cor_done_w) z_q <= cor_z;
      ST_ROT_W: begin
        if (cor_done_w) begin
          cos_q <= cor_x;
          sin_q <= cor_y;
        end
      end
      ST_S1_W: begin
        if (div_done) s1_q <= (sin_q < 0) ? -$signed(s1m) : $signed(s1m);
      end
      ST_DS_A:  s0_q <= MW'(PW'(cos_q) - ds_rnd);
      ST_SL_A:  acc_q <= mul_p;
      ST_SL_A2: oq_q[idx_q] <= sat_ori(sl_sum);
      ST_FIN: begin
        if (out_free) begin
          out_q.out_x           <= opos_q[0];
          out_q.out_y           <= opos_q[1];
          out_q.out_z           <= opos_q[2];
          out_q.out_qw          <= oq_q[0];
          out_q.out_qx          <= oq_q[1];
          out_q.out_qy          <= oq_q[2];
          out_q.out_qz          <= oq_q[3];
          out_q.out_pos_conf    <= pc_q;
          out_q.out_orient_conf <= oc_q;
          out_q.out_valid       <= vld_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  psi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  psi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quot_o     (div_q),
    .done_o     (div_done)
  );

  psi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  psi_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .x0_i   (cor_x0),
    .y0_i   (cor_y0),
    .z0_i   (cor_z0),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z),
    .done_o (cor_done_w)
  );

endmodule

>>> rtl/psi_checker.sv
module psi_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input psi_pkg::in_item_t   in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input psi_pkg::out_item_t  out_data_o
);
  import psi_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // An interpolate transfer occupies the block
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.action |=> in_stall_o)
    else $error("input not stalled after interpolate transfer");

  // A store transfer yields no result
  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.action && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a store transfer");

  // Results appear only at the end of an item in work
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in work");

endmodule

bind pose_slerp_interpolator psi_checker u_psi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
